>>> hw/rtl/tabular_q_learning_agent_core_assert.svh
// Assertion macros shared by the RTL of the Q-learning agent core.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef TABULAR_Q_LEARNING_AGENT_CORE_ASSERT_SVH
`define TABULAR_Q_LEARNING_AGENT_CORE_ASSERT_SVH

// Same-cycle implication
`define TQLA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TQLA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tqla_pkg.sv
// ----------------------------------------------------------------------------
// tqla_pkg
// Types, constants and helper functions of the tabular Q-learning agent core.
// ----------------------------------------------------------------------------
package tqla_pkg;

	// Table geometry
	localparam int STATES     = 4096;
	localparam int ACTIONS    = 4;
	localparam int VALUE_BITS = 32;
	localparam int ST_BITS    = $clog2(STATES);
	localparam int ACT_BITS   = $clog2(ACTIONS);
	localparam int ROW_BITS   = ACTIONS * VALUE_BITS;
	localparam int CNT_BITS   = $clog2(STATES + 1);

	// Wide signed working width for sums before saturation
	localparam int WIDE_BITS  = 36;

	// Rates are Q1.16, 17 bits so that 1.0 is representable
	localparam int RATE_BITS  = 17;
	localparam logic [RATE_BITS-1:0] ONE_Q16 = 17'h10000;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEARNING_RATE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISCOUNT      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EPS_START     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EPS_END       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EPS_STEPS     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED          = 3'd5;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIXA   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIXB   = 64'h94D049BB133111EB;

	// Epsilon divider: 17-bit magnitude times 32-bit count
	localparam int DIV_BITS = RATE_BITS + 32;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_LEARN   = 2'd0,
		OP_GREEDY  = 2'd1,
		OP_EXPLORE = 2'd2,
		OP_READ    = 2'd3
	} op_e;

	// Datapath commands
	typedef enum logic [4:0] {
		CMD_IDLE,
		CMD_CLEAR,
		CMD_LATCH,
		CMD_RD_NEXT,
		CMD_MAX,
		CMD_MUL_DISC,
		CMD_TARGET,
		CMD_ERR,
		CMD_MUL_LR,
		CMD_WRITE,
		CMD_PICK,
		CMD_READ_VAL,
		CMD_EPS_INIT,
		CMD_DIV_STEP,
		CMD_EPS_FIN,
		CMD_RNG_ADV,
		CMD_MUL_LL,
		CMD_MUL_LH,
		CMD_MUL_HL,
		CMD_MIX2,
		CMD_FIN,
		CMD_TEST,
		CMD_RAND_PICK,
		CMD_EMIT
	} cmd_op_e;

	typedef struct packed {
		cmd_op_e            op;
		logic [ST_BITS-1:0] clr_addr;
	} cmd_t;

	typedef struct packed {
		logic eps_direct;
		logic below;
	} status_t;

	typedef logic signed [VALUE_BITS-1:0] qval_t;

	// Rates above 1.0 act as 1.0
	function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [RATE_BITS-1:0] r);
		return (r > ONE_Q16) ? ONE_Q16 : r;
	endfunction

	// Saturate a wide signed value to the table value width
	function automatic qval_t sat_value(input logic signed [WIDE_BITS-1:0] x);
		logic [WIDE_BITS-VALUE_BITS:0] top;
		top = x[WIDE_BITS-1:VALUE_BITS-1];
		if ((&top) || !(|top)) begin
			return x[VALUE_BITS-1:0];
		end else if (x[WIDE_BITS-1]) begin
			return {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

>>> hw/rtl/tqla_if.sv
// ----------------------------------------------------------------------------
// tqla_in_if / tqla_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tqla_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [11:0]        state_index;
	logic [1:0]         move;
	logic signed [31:0] reward;
	logic [11:0]        dest_state;
	logic               died;

	modport source (output valid, action, state_index, move, reward, dest_state, died,
		input ready);
	modport sink (input valid, action, state_index, move, reward, dest_state, died,
		output ready);
endinterface

interface tqla_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         chosen_move;
	logic signed [31:0] value_out;
	logic [12:0]        visited_count;
	logic               explored;

	modport source (output valid, chosen_move, value_out, visited_count, explored,
		input ready);
	modport sink (input valid, chosen_move, value_out, visited_count, explored,
		output ready);
endinterface

>>> hw/rtl/tabular_q_learning_agent_core.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_core
// Tabular Q-learning engine: learn, greedy pick, epsilon-greedy pick, read.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  items    | in  | valid/ready   | action, state_index, move, reward, dest_state, died
//  results  | out | valid/ready   | chosen_move, value_out, visited_count, explored
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (write only)
//
// Explore items run the 49-step epsilon divider and its finishing step while
// the schedule is active; a random pick runs a second splitmix64 draw on the
// shared 32x32 multiplier. After reset the table and visited memories are
// cleared with items held off. A waiting result in the output register does
// not stall intake; a finished item waits in its last step until that register
// is free.
`include "tabular_q_learning_agent_core_assert.svh"

module tabular_q_learning_agent_core (
	input  logic                                clk,
	input  logic                                arst_n,
	tqla_in_if.sink                             items,
	tqla_out_if.source                          results,
	input  logic                                cfg_we,
	input  logic [tqla_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tqla_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import tqla_pkg::*;

	cmd_t    cmd;
	status_t stat;

	tqla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_action (items.action),
		.out_ready (results.ready),
		.stat      (stat),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.cmd       (cmd)
	);

	tqla_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.state_index   (items.state_index),
		.move          (items.move),
		.reward        (items.reward),
		.dest_state    (items.dest_state),
		.died          (items.died),
		.chosen_move   (results.chosen_move),
		.value_out     (results.value_out),
		.visited_count (results.visited_count),
		.explored      (results.explored)
	);

	// An accepted item keeps intake closed while it is worked on
	`TQLA_ASSERT_NXT(a_busy_after_accept, items.valid && items.ready, !items.ready, "intake open")
	// A result only appears at the end of work, never straight from idle
	`TQLA_ASSERT_IMP(a_result_from_work, $rose(results.valid), !$past(items.ready), "idle result")

endmodule

>>> hw/rtl/tqla_ram.sv
// ----------------------------------------------------------------------------
// tqla_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tqla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/tqla_ctrl.sv
// ----------------------------------------------------------------------------
// tqla_ctrl
// Sequencer: clears the memories after reset, then steps each item through
// the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module tqla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_action,
	input  logic              out_ready,
	input  tqla_pkg::status_t stat,
	output logic              in_ready,
	output logic              out_valid,
	output tqla_pkg::cmd_t    cmd
);
	import tqla_pkg::*;

	localparam int DIV_LAST = DIV_BITS - 1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_LN_RDNX, S_LN_MAX, S_LN_MULD, S_LN_TGT, S_LN_ERR, S_LN_MULR, S_LN_WR,
		S_GR_RD, S_GR_PICK, S_RD_RD, S_RD_VAL,
		S_EP_INIT, S_EP_DIV, S_EP_FIN,
		S_EX_ADV, S_EX_LL, S_EX_LH, S_EX_HL, S_EX_MIX2, S_EX_FIN, S_EX_TEST, S_EX_RAND,
		S_RESULT
	} state_e;

	state_e             state_q;
	logic [ST_BITS-1:0] cnt_q;
	logic               mix_q;
	logic               second_q;
	logic               out_valid_q;
	logic               emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	// Command decode
	always_comb begin
		cmd.clr_addr = cnt_q;
		unique case (state_q)
			S_CLEAR:   cmd.op = CMD_CLEAR;
			S_IDLE:    cmd.op = in_valid ? CMD_LATCH : CMD_IDLE;
			S_LN_RDNX: cmd.op = CMD_RD_NEXT;
			S_LN_MAX:  cmd.op = CMD_MAX;
			S_LN_MULD: cmd.op = CMD_MUL_DISC;
			S_LN_TGT:  cmd.op = CMD_TARGET;
			S_LN_ERR:  cmd.op = CMD_ERR;
			S_LN_MULR: cmd.op = CMD_MUL_LR;
			S_LN_WR:   cmd.op = CMD_WRITE;
			S_GR_RD:   cmd.op = CMD_IDLE;
			S_GR_PICK: cmd.op = CMD_PICK;
			S_RD_RD:   cmd.op = CMD_IDLE;
			S_RD_VAL:  cmd.op = CMD_READ_VAL;
			S_EP_INIT: cmd.op = CMD_EPS_INIT;
			S_EP_DIV:  cmd.op = CMD_DIV_STEP;
			S_EP_FIN:  cmd.op = CMD_EPS_FIN;
			S_EX_ADV:  cmd.op = CMD_RNG_ADV;
			S_EX_LL:   cmd.op = CMD_MUL_LL;
			S_EX_LH:   cmd.op = CMD_MUL_LH;
			S_EX_HL:   cmd.op = CMD_MUL_HL;
			S_EX_MIX2: cmd.op = CMD_MIX2;
			S_EX_FIN:  cmd.op = CMD_FIN;
			S_EX_TEST: cmd.op = CMD_TEST;
			S_EX_RAND: cmd.op = CMD_RAND_PICK;
			S_RESULT:  cmd.op = emit ? CMD_EMIT : CMD_IDLE;
			default:   cmd.op = CMD_IDLE;
		endcase
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			mix_q       <= 1'b0;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register: load on emit, free on transfer
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						unique case (op_e'(in_action))
							OP_LEARN:   state_q <= S_LN_RDNX;
							OP_GREEDY:  state_q <= S_GR_RD;
							OP_EXPLORE: state_q <= S_EP_INIT;
							OP_READ:    state_q <= S_RD_RD;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_LN_RDNX: state_q <= S_LN_MAX;
				S_LN_MAX:  state_q <= S_LN_MULD;
				S_LN_MULD: state_q <= S_LN_TGT;
				S_LN_TGT:  state_q <= S_LN_ERR;
				S_LN_ERR:  state_q <= S_LN_MULR;
				S_LN_MULR: state_q <= S_LN_WR;
				S_LN_WR:   state_q <= S_RESULT;
				S_GR_RD:   state_q <= S_GR_PICK;
				S_GR_PICK: state_q <= S_RESULT;
				S_RD_RD:   state_q <= S_RD_VAL;
				S_RD_VAL:  state_q <= S_RESULT;
				S_EP_INIT: begin
					second_q <= 1'b0;
					cnt_q    <= '0;
					state_q  <= stat.eps_direct ? S_EX_ADV : S_EP_DIV;
				end
				S_EP_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ST_BITS'(DIV_LAST)) begin
						state_q <= S_EP_FIN;
					end
				end
				S_EP_FIN: state_q <= S_EX_ADV;
				S_EX_ADV: begin
					mix_q   <= 1'b0;
					state_q <= S_EX_LL;
				end
				S_EX_LL:   state_q <= S_EX_LH;
				S_EX_LH:   state_q <= S_EX_HL;
				S_EX_HL:   state_q <= mix_q ? S_EX_FIN : S_EX_MIX2;
				S_EX_MIX2: begin
					mix_q   <= 1'b1;
					state_q <= S_EX_LL;
				end
				S_EX_FIN:  state_q <= second_q ? S_EX_RAND : S_EX_TEST;
				S_EX_TEST: begin
					if (stat.below) begin
						second_q <= 1'b1;
						state_q  <= S_EX_ADV;
					end else begin
						state_q  <= S_GR_RD;
					end
				end
				S_EX_RAND: state_q <= S_RESULT;
				S_RESULT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/tqla_datapath.sv
// ----------------------------------------------------------------------------
// tqla_datapath
// Q-table and visited memories, configuration registers, fixed-point update
// arithmetic, epsilon divider and splitmix64 generator.
// ----------------------------------------------------------------------------
module tqla_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tqla_pkg::cmd_t                      cmd,
	output tqla_pkg::status_t                   stat,
	input  logic                                cfg_we,
	input  logic [tqla_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tqla_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [tqla_pkg::ST_BITS-1:0]        state_index,
	input  logic [tqla_pkg::ACT_BITS-1:0]       move,
	input  logic signed [31:0]                  reward,
	input  logic [tqla_pkg::ST_BITS-1:0]        dest_state,
	input  logic                                died,
	output logic [1:0]                          chosen_move,
	output logic signed [31:0]                  value_out,
	output logic [12:0]                         visited_count,
	output logic                                explored
);
	import tqla_pkg::*;

	// Configuration and persistent state
	logic [RATE_BITS-1:0] lr_q, disc_q, eps_s_q, eps_e_q;
	logic [31:0]          eps_steps_q;
	logic [63:0]          rng_q;
	logic [31:0]          count_q;
	logic [CNT_BITS-1:0]  total_q;

	// Item and working registers
	logic [ST_BITS-1:0]   st_q, nx_q;
	logic [ACT_BITS-1:0]  mv_q;
	qval_t                reward_q;
	logic                 died_q;
	qval_t                max_q, target_q, entry_q;
	logic                 vis_q;
	logic [ROW_BITS-1:0]  row_q;
	logic signed [VALUE_BITS:0] err_q;
	logic [49:0]          prod_q;
	logic                 sgn_q;
	logic [RATE_BITS-1:0] eps_q;
	logic                 eneg_q;
	logic [DIV_BITS-1:0]  dq_q;
	logic [32:0]          rem_q;
	logic [63:0]          z_q, acc_q, draw_q;
	logic                 ksel_q;

	// Result staging
	logic [ACT_BITS-1:0]  res_chosen_q;
	qval_t                res_val_q;
	logic                 res_expl_q;

	// Memory ports
	logic                 q_we, v_we;
	logic [ST_BITS-1:0]   q_addr, v_addr;
	logic [ROW_BITS-1:0]  q_wdata, q_rdata, wrow;
	logic                 v_wdata, v_rdata;

	// Combinational helpers
	logic [ACT_BITS-1:0]  best_idx;
	qval_t                best_val;
	logic [33:0]          rnd_mag;
	logic signed [WIDE_BITS-1:0] term;
	qval_t                new_entry;
	logic [VALUE_BITS:0]  max_mag, err_mag;
	logic [RATE_BITS-1:0] s_cl, e_cl, eps_mag;
	logic                 eps_neg;
	logic [32:0]          div_sh;
	logic                 div_ge;
	logic [63:0]          rng_nxt, kmul, mul_p;
	logic [31:0]          mul_a, mul_b;

	tqla_ram #(.WIDTH(ROW_BITS), .DEPTH(STATES)) u_qram (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
	);

	tqla_ram #(.WIDTH(1), .DEPTH(STATES)) u_vram (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);

	// Memory address and write control
	always_comb begin
		q_we    = (cmd.op == CMD_CLEAR) || (cmd.op == CMD_WRITE);
		v_we    = q_we;
		q_wdata = (cmd.op == CMD_CLEAR) ? '0 : wrow;
		v_wdata = (cmd.op == CMD_WRITE);
		v_addr  = (cmd.op == CMD_CLEAR) ? cmd.clr_addr : st_q;
		q_addr  = st_q;
		if (cmd.op == CMD_CLEAR) begin
			q_addr = cmd.clr_addr;
		end else if (cmd.op == CMD_RD_NEXT) begin
			q_addr = nx_q;
		end
	end

	// Row argmax, ties to the lowest index
	always_comb begin
		best_idx = '0;
		best_val = q_rdata[VALUE_BITS-1:0];
		for (int a = 1; a < ACTIONS; a++) begin
			if ($signed(q_rdata[a*VALUE_BITS +: VALUE_BITS]) > best_val) begin
				best_idx = ACT_BITS'(a);
				best_val = q_rdata[a*VALUE_BITS +: VALUE_BITS];
			end
		end
	end

	// Rounded rate product, halves away from zero, sign restored
	assign rnd_mag = 34'((prod_q + 50'd32768) >> 16);
	assign term    = sgn_q ? -$signed({2'b00, rnd_mag}) : $signed({2'b00, rnd_mag});

	assign new_entry = sat_value(WIDE_BITS'(entry_q) + term);

	always_comb begin
		wrow = row_q;
		wrow[mv_q*VALUE_BITS +: VALUE_BITS] = new_entry;
	end

	assign max_mag = max_q[VALUE_BITS-1] ? 33'(-(VALUE_BITS+1)'(max_q)) : 33'(max_q);
	assign err_mag = err_q[VALUE_BITS] ? 33'(-err_q) : 33'(err_q);

	// Epsilon schedule
	assign s_cl    = clamp_rate(eps_s_q);
	assign e_cl    = clamp_rate(eps_e_q);
	assign eps_neg = e_cl < s_cl;
	assign eps_mag = eps_neg ? (s_cl - e_cl) : (e_cl - s_cl);
	assign stat.eps_direct = (eps_steps_q == 32'd0) || (count_q >= eps_steps_q);

	// Restoring divider step
	assign div_sh = {rem_q[31:0], dq_q[DIV_BITS-1]};
	assign div_ge = div_sh >= {1'b0, eps_steps_q};

	// splitmix64 with a shared 32x32 multiplier
	assign rng_nxt = rng_q + GOLDEN;
	assign kmul    = ksel_q ? MIXB : MIXA;
	always_comb begin
		mul_a = z_q[31:0];
		mul_b = kmul[31:0];
		if (cmd.op == CMD_MUL_LH) begin
			mul_b = kmul[63:32];
		end else if (cmd.op == CMD_MUL_HL) begin
			mul_a = z_q[63:32];
		end
	end
	assign mul_p = mul_a * mul_b;

	assign stat.below = {1'b0, draw_q[63:11]} < {eps_q, 37'b0};

	// Control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q        <= 17'd6554;
			disc_q      <= 17'd58982;
			eps_s_q     <= 17'd65536;
			eps_e_q     <= 17'd3277;
			eps_steps_q <= '0;
			rng_q       <= '0;
			count_q     <= '0;
			total_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEARNING_RATE: lr_q        <= cfg_data[RATE_BITS-1:0];
					CFG_DISCOUNT:      disc_q      <= cfg_data[RATE_BITS-1:0];
					CFG_EPS_START:     eps_s_q     <= cfg_data[RATE_BITS-1:0];
					CFG_EPS_END:       eps_e_q     <= cfg_data[RATE_BITS-1:0];
					CFG_EPS_STEPS:     eps_steps_q <= cfg_data[31:0];
					CFG_SEED:          rng_q       <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == CMD_RNG_ADV) begin
				rng_q <= rng_nxt;
			end
			if ((cmd.op == CMD_TEST) && !(&count_q)) begin
				count_q <= count_q + 1'b1;
			end
			if ((cmd.op == CMD_WRITE) && !vis_q) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CMD_LATCH: begin
				st_q         <= state_index;
				nx_q         <= dest_state;
				mv_q         <= move;
				reward_q     <= reward;
				died_q       <= died;
				res_chosen_q <= '0;
				res_val_q    <= '0;
				res_expl_q   <= 1'b0;
			end
			CMD_MAX: begin
				max_q <= best_val;
				vis_q <= v_rdata;
			end
			CMD_MUL_DISC: begin
				prod_q <= {17'b0, max_mag} * {33'b0, clamp_rate(disc_q)};
				sgn_q  <= max_q[VALUE_BITS-1];
				row_q  <= q_rdata;
			end
			CMD_TARGET: begin
				target_q <= died_q ? reward_q : sat_value(WIDE_BITS'(reward_q) + term);
				entry_q  <= row_q[mv_q*VALUE_BITS +: VALUE_BITS];
			end
			CMD_ERR: begin
				err_q     <= (VALUE_BITS+1)'(target_q) - (VALUE_BITS+1)'(entry_q);
				res_val_q <= sat_value(WIDE_BITS'((VALUE_BITS+1)'(target_q)
					- (VALUE_BITS+1)'(entry_q)));
			end
			CMD_MUL_LR: begin
				prod_q <= {17'b0, err_mag} * {33'b0, clamp_rate(lr_q)};
				sgn_q  <= err_q[VALUE_BITS];
			end
			CMD_PICK:     res_chosen_q <= best_idx;
			CMD_READ_VAL: res_val_q    <= q_rdata[mv_q*VALUE_BITS +: VALUE_BITS];
			CMD_EPS_INIT: begin
				eps_q  <= e_cl;
				eneg_q <= eps_neg;
				dq_q   <= {32'b0, eps_mag} * {17'b0, count_q};
				rem_q  <= '0;
			end
			CMD_DIV_STEP: begin
				rem_q <= div_ge ? (div_sh - {1'b0, eps_steps_q}) : div_sh;
				dq_q  <= {dq_q[DIV_BITS-2:0], div_ge};
			end
			CMD_EPS_FIN: begin
				eps_q <= eneg_q ? (s_cl - dq_q[RATE_BITS-1:0]) : (s_cl + dq_q[RATE_BITS-1:0]);
			end
			CMD_RNG_ADV: begin
				z_q    <= rng_nxt ^ (rng_nxt >> 30);
				ksel_q <= 1'b0;
			end
			CMD_MUL_LL: acc_q <= mul_p;
			CMD_MUL_LH: acc_q <= acc_q + {mul_p[31:0], 32'b0};
			CMD_MUL_HL: acc_q <= acc_q + {mul_p[31:0], 32'b0};
			CMD_MIX2: begin
				z_q    <= acc_q ^ (acc_q >> 27);
				ksel_q <= 1'b1;
			end
			CMD_FIN: draw_q <= acc_q ^ (acc_q >> 31);
			CMD_RAND_PICK: begin
				res_chosen_q <= draw_q[ACT_BITS-1:0];
				res_expl_q   <= 1'b1;
			end
			CMD_EMIT: begin
				chosen_move   <= res_chosen_q;
				value_out     <= res_val_q;
				visited_count <= total_q;
				explored      <= res_expl_q;
			end
			default: ;
		endcase
	end

endmodule

>>> verif/tb_tabular_q_learning_agent_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tabular_q_learning_agent_core
// Self-checking bench for the Q-learning agent core. Learn, greedy, explore
// and read items are sent over the item channel. A local table and
// epsilon/splitmix64 tracker predict each result. Results are compared in
// order with random gaps, back-pressure and several rate settings.
// ----------------------------------------------------------------------------
module tb_tabular_q_learning_agent_core;
	import tqla_pkg::*;

	typedef struct {
		op_e                op;
		logic [11:0]        st;
		logic [1:0]         mv;
		logic signed [31:0] rw;
		logic [11:0]        nx;
		logic               died;
	} agent_item_t;

	typedef struct {
		logic [1:0]         mv;
		logic signed [31:0] val;
		logic [12:0]        cnt;
		logic               expl;
	} agent_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	tqla_in_if  item_ch();
	tqla_out_if result_ch();

	tabular_q_learning_agent_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (item_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the agent state
	logic signed [31:0] q_mem [0:16383];
	bit                 seen_row [0:4095];
	int unsigned        seen_total;
	int unsigned        sel_cnt;
	bit [63:0]          rng_st;
	longint             lr_r, disc_r, eps_s_r, eps_e_r;
	longint             eps_steps_r;

	agent_result_t pending_q[$];
	int            errors;
	bit            calm;
	int            hold_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------- predictor ----------------
	function automatic longint clamp_q16(longint r);
		return (r > 65536) ? 65536 : r;
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// |v|*r rounded half away from zero, then >> 16, sign restored
	function automatic longint scale_rate(longint v, longint r);
		longint m, p;
		bit neg;
		neg = v < 0;
		m = neg ? -v : v;
		p = (m * r + 32768) >>> 16;
		return neg ? -p : p;
	endfunction

	function automatic int best_col(int row);
		int b;
		b = 0;
		for (int a = 1; a < 4; a++)
			if (q_mem[row*4+a] > q_mem[row*4+b]) b = a;
		return b;
	endfunction

	function automatic bit [63:0] splitmix_next();
		bit [63:0] z;
		rng_st = rng_st + GOLDEN;
		z = rng_st;
		z = (z ^ (z >> 30)) * MIXA;
		z = (z ^ (z >> 27)) * MIXB;
		return z ^ (z >> 31);
	endfunction

	function automatic longint epsilon_now();
		longint s, e, d, mag, q;
		s = clamp_q16(eps_s_r);
		e = clamp_q16(eps_e_r);
		if (eps_steps_r == 0 || longint'(sel_cnt) >= eps_steps_r) return e;
		d = e - s;
		mag = (d < 0) ? -d : d;
		q = (mag * longint'(sel_cnt)) / eps_steps_r;
		return (d < 0) ? s - q : s + q;
	endfunction

	function automatic agent_result_t agent_predict(agent_item_t it);
		agent_result_t r;
		longint tgt, err, mx, entry;
		bit [63:0] thr;
		int idx;
		r.mv = 0;
		r.val = 0;
		r.expl = 0;
		case (it.op)
			OP_LEARN: begin
				idx = it.st * 4 + it.mv;
				entry = q_mem[idx];
				tgt = it.rw;
				if (!it.died) begin
					mx = q_mem[it.nx*4 + best_col(it.nx)];
					tgt = sat32(tgt + scale_rate(mx, clamp_q16(disc_r)));
				end
				err = tgt - entry;
				q_mem[idx] = 32'(sat32(entry + scale_rate(err, clamp_q16(lr_r))));
				if (!seen_row[it.st]) begin
					seen_row[it.st] = 1;
					seen_total++;
				end
				r.val = 32'(sat32(err));
			end
			OP_GREEDY: r.mv = 2'(best_col(it.st));
			OP_EXPLORE: begin
				thr = 64'(epsilon_now()) << 37;
				if (sel_cnt != 32'hFFFF_FFFF) sel_cnt++;
				if ((splitmix_next() >> 11) < thr) begin
					r.mv = 2'(splitmix_next() % 4);
					r.expl = 1;
				end else begin
					r.mv = 2'(best_col(it.st));
				end
			end
			default: r.val = q_mem[it.st*4 + it.mv];
		endcase
		r.cnt = seen_total[12:0];
		return r;
	endfunction

	// ---------------- drivers ----------------
	// Send one item; valid stays high after the transfer
	task automatic send_item(agent_item_t it);
		while (!calm && $urandom_range(99) < 6) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.action      <= it.op;
		item_ch.state_index <= it.st;
		item_ch.move        <= it.mv;
		item_ch.reward      <= it.rw;
		item_ch.dest_state  <= it.nx;
		item_ch.died        <= it.died;
		do @(posedge clk); while (!item_ch.ready);
		pending_q.insert(pending_q.size(), agent_predict(it));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One register write, one cycle of write enable
	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_LEARNING_RATE: lr_r    = val[16:0];
			CFG_DISCOUNT:      disc_r  = val[16:0];
			CFG_EPS_START:     eps_s_r = val[16:0];
			CFG_EPS_END:       eps_e_r = val[16:0];
			CFG_EPS_STEPS:     eps_steps_r = val[31:0];
			CFG_SEED:          rng_st  = val;
			default: ;
		endcase
	endtask

	function automatic agent_item_t mk(op_e op, int st, int mv, longint rw, int nx, bit died);
		agent_item_t it;
		it.op = op;
		it.st = 12'(st);
		it.mv = 2'(mv);
		it.rw = 32'(rw);
		it.nx = 12'(nx);
		it.died = died;
		return it;
	endfunction

	function automatic agent_item_t rand_item();
		agent_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.op = (pick < 40) ? OP_LEARN : (pick < 60) ? OP_GREEDY :
			(pick < 85) ? OP_EXPLORE : OP_READ;
		// Mostly a small set of rows so learning feeds greedy picks
		it.st = 12'(($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(7));
		it.nx = 12'(($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(7));
		it.mv = 2'($urandom_range(3));
		case ($urandom_range(9))
			0: it.rw = $urandom;
			1: it.rw = ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: it.rw = $signed($urandom_range(20 * 65536)) - 10 * 65536;
		endcase
		it.died = ($urandom_range(3) == 0);
		return it;
	endfunction

	// ---------------- result side ----------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// Compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		agent_result_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result mv=%0d val=%h", $time,
					result_ch.chosen_move, result_ch.value_out);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (result_ch.chosen_move !== e.mv) begin
					$display("%0t: chosen_move exp %0d got %0d", $time, e.mv,
						result_ch.chosen_move);
					errors++;
				end
				if (result_ch.value_out !== e.val) begin
					$display("%0t: value_out exp %h got %h", $time, e.val,
						result_ch.value_out);
					errors++;
				end
				if (result_ch.visited_count !== e.cnt) begin
					$display("%0t: visited_count exp %0d got %0d", $time, e.cnt,
						result_ch.visited_count);
					errors++;
				end
				if (result_ch.explored !== e.expl) begin
					$display("%0t: explored exp %0d got %0d", $time, e.expl,
						result_ch.explored);
					errors++;
				end
			end
		end
	end

	// ---------------- tests ----------------
	// Reset defaults: ties, terminal and bootstrapped learns, field extremes
	task automatic test_directed_basics();
		send_item(mk(OP_GREEDY, 0, 0, 0, 0, 0));
		send_item(mk(OP_READ, 4095, 3, 0, 0, 0));
		send_item(mk(OP_LEARN, 0, 0, 32'sh7FFF_FFFF, 0, 1));
		send_item(mk(OP_LEARN, 0, 1, -64'sd2147483648, 0, 1));
		send_item(mk(OP_LEARN, 4095, 3, 65536, 0, 0));
		send_item(mk(OP_LEARN, 1, 2, -65536, 4095, 0));
		send_item(mk(OP_LEARN, 0, 0, 0, 0, 0));
		send_item(mk(OP_GREEDY, 0, 0, 0, 0, 0));
		send_item(mk(OP_GREEDY, 4095, 0, 0, 0, 0));
		send_item(mk(OP_READ, 0, 0, 0, 0, 0));
		send_item(mk(OP_READ, 0, 1, 0, 0, 0));
		send_item(mk(OP_EXPLORE, 0, 0, 0, 0, 0));
		send_item(mk(OP_EXPLORE, 4095, 0, 0, 0, 0));
		drain();
	endtask

	// Rate extremes: full step, above-one clamp, smallest step, saturation
	task automatic test_rate_extremes();
		cfg_write(CFG_LEARNING_RATE, 65536);
		cfg_write(CFG_DISCOUNT, 65536);
		cfg_write(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(mk(OP_LEARN, 5, 3, 32'sh7FFF_FFFF, 5, 0));
		send_item(mk(OP_LEARN, 5, 3, 32'sh7FFF_FFFF, 5, 0));
		send_item(mk(OP_LEARN, 6, 0, -64'sd2147483648, 5, 0));
		send_item(mk(OP_READ, 5, 3, 0, 0, 0));
		drain();
		cfg_write(CFG_LEARNING_RATE, 17'h1FFFF);
		cfg_write(CFG_DISCOUNT, 0);
		send_item(mk(OP_LEARN, 6, 0, 12345, 5, 0));
		drain();
		cfg_write(CFG_LEARNING_RATE, 1);
		cfg_write(CFG_DISCOUNT, 17'h1FFFF);
		send_item(mk(OP_LEARN, 7, 1, 32769, 5, 0));
		send_item(mk(OP_READ, 7, 1, 0, 0, 0));
		drain();
	endtask

	// Linear epsilon fall from always-explore to never over a short schedule, then a rise over a long one
	task automatic test_epsilon_schedule();
		cfg_write(CFG_EPS_START, 17'h1FFFF);
		cfg_write(CFG_EPS_END, 0);
		cfg_write(CFG_EPS_STEPS, 40);
		cfg_write(CFG_SEED, 64'h0123_4567_89AB_CDEF);
		for (int i = 0; i < 50; i++)
			send_item(mk(OP_EXPLORE, $urandom_range(7), 0, 0, 0, 0));
		drain();
		cfg_write(CFG_EPS_START, 0);
		cfg_write(CFG_EPS_END, 65536);
		cfg_write(CFG_EPS_STEPS, 32'hFFFF_FFFF);
		for (int i = 0; i < 10; i++)
			send_item(mk(OP_EXPLORE, $urandom_range(7), 0, 0, 0, 0));
		drain();
	endtask

	// Receiver holds off while items keep coming, then sender waits it out
	task automatic test_backpressure();
		calm = 1;
		hold_left = 300;
		for (int i = 0; i < 12; i++) send_item(rand_item());
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		for (int i = 0; i < 12; i++) send_item(rand_item());
		calm = 0;
		drain();
	endtask

	// Random items across several settings, with one stretch of no idling
	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			cfg_write(CFG_LEARNING_RATE, 64'((ph == 0) ? 6554 : $urandom_range(65536, 1)));
			cfg_write(CFG_DISCOUNT, 64'((ph == 1) ? 65536 : $urandom_range(65536)));
			cfg_write(CFG_EPS_START, 64'($urandom_range(65536)));
			cfg_write(CFG_EPS_END, 64'($urandom_range(65536)));
			cfg_write(CFG_EPS_STEPS, 64'((ph == 2) ? 0 : sel_cnt + $urandom_range(150)));
			cfg_write(CFG_SEED, {$urandom, $urandom});
			calm = (ph == 2);
			for (int i = 0; i < 90; i++) send_item(rand_item());
			calm = 0;
			drain();
		end
	endtask

	// ---------------- sequence ----------------
	initial begin
		errors = 0;
		calm = 0;
		hold_left = 0;
		item_ch.valid = 1'b0;
		item_ch.action = OP_LEARN;
		item_ch.state_index = '0;
		item_ch.move = '0;
		item_ch.reward = '0;
		item_ch.dest_state = '0;
		item_ch.died = 1'b0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 16384; i++) q_mem[i] = 0;
		for (int i = 0; i < 4096; i++) seen_row[i] = 0;
		seen_total = 0;
		sel_cnt = 0;
		rng_st = 0;
		lr_r = 6554;
		disc_r = 58982;
		eps_s_r = 65536;
		eps_e_r = 3277;
		eps_steps_r = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_rate_extremes();
		test_epsilon_schedule();
		test_backpressure();
		test_random_traffic();

		repeat (100) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
